// File: rtl/dhcp_option_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// DHCP option field extractor assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DHCP_OPTION_FIELD_EXTRACTOR_MACROS_SVH
`define DHCP_OPTION_FIELD_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOFE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhcp option field extractor: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DOFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhcp option field extractor: assertion failed");

`endif

// File: rtl/dofe_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor package
// Payload types, job descriptor, record kinds and shared constants.
// ----------------------------------------------------------------------------
package dofe_pkg;

  localparam int unsigned DefMaxHostname  = 32;
  localparam int unsigned DefMaxCommunity = 32;
  localparam int unsigned DefMaxHosts     = 8;
  localparam int unsigned DefQueueDepth   = 4;

  localparam int unsigned IdxW    = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] AUTH_CODE_RESET = 8'd230;
  localparam logic [7:0] COMM_CODE_RESET = 8'd231;

  localparam logic [CfgIdxW-1:0] REG_AUTH_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COMM_CODE = 2'd1;

  localparam logic [3:0] KIND_MSGTYPE   = 4'd0;
  localparam logic [3:0] KIND_SERVER    = 4'd1;
  localparam logic [3:0] KIND_SUBNET    = 4'd2;
  localparam logic [3:0] KIND_ROUTER    = 4'd3;
  localparam logic [3:0] KIND_LEASE     = 4'd4;
  localparam logic [3:0] KIND_HOST_BYTE = 4'd5;
  localparam logic [3:0] KIND_HOST_ADDR = 4'd7;
  localparam logic [3:0] KIND_COMM_BYTE = 4'd9;
  localparam logic [3:0] KIND_DONE      = 4'd11;

  localparam logic [1:0] DONE_END     = 2'd0;
  localparam logic [1:0] DONE_RAN_OUT = 2'd1;
  localparam logic [1:0] DONE_TRUNC   = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_WORD,
    OP_STR,
    OP_HOST
  } op_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]      kind;
    logic [31:0]     value;
    logic [IdxW-1:0] index;
    logic            last;
  } out_item_t;

  typedef struct packed {
    op_e             op;
    logic [3:0]      kind;
    logic [IdxW-1:0] limit;
    logic            done_en;
    logic [1:0]      done_val;
  } job_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } store_wr_t;

endpackage

// File: rtl/dofe_front.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor front end
// Parses the option byte stream, fills the value store and queues one job
// for every byte that causes records.
// ----------------------------------------------------------------------------
module dofe_front
  import dofe_pkg::*;
#(
  parameter int unsigned MaxHostname  = DefMaxHostname,
  parameter int unsigned MaxCommunity = DefMaxCommunity,
  parameter int unsigned MaxHosts     = DefMaxHosts,
  parameter int unsigned StoreDepth   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               q_full_i,
  input  logic               q_empty_i,
  input  logic               back_busy_i,
  output logic               push_o,
  output job_t               job_o,
  output store_wr_t          wr_o
);

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] code_q, code_d;
  logic [7:0] left_q, left_d;
  logic [7:0] taken_q, taken_d;
  logic [7:0] auth_q, comm_q;

  logic       acc;
  logic [7:0] b;
  logic       fin;
  logic [7:0] cls_len;
  op_e        cls_op;
  logic [3:0] cls_kind;
  logic [IdxW-1:0] cls_limit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i || ((phase_q == PH_VALUE) && (back_busy_i || !q_empty_i));
  assign acc         = in_valid_i && !in_stall_o;
  assign b           = in_data_i.stream_byte;
  assign fin         = in_data_i.last_byte;
  assign cls_len     = (phase_q == PH_LEN) ? 8'd0 : taken_q + 8'd1;

  always_comb begin
    cls_op    = OP_NONE;
    cls_kind  = KIND_MSGTYPE;
    cls_limit = '0;
    case (code_q)
      8'd53: begin
        if (cls_len >= 8'd1) begin
          cls_op    = OP_BYTE;
          cls_kind  = KIND_MSGTYPE;
          cls_limit = IdxW'(1);
        end
      end
      8'd54: begin
        if (cls_len == 8'd4) begin
          cls_op    = OP_WORD;
          cls_kind  = KIND_SERVER;
          cls_limit = IdxW'(1);
        end
      end
      8'd1: begin
        if (cls_len == 8'd4) begin
          cls_op    = OP_WORD;
          cls_kind  = KIND_SUBNET;
          cls_limit = IdxW'(1);
        end
      end
      8'd3: begin
        if (cls_len >= 8'd4) begin
          cls_op    = OP_WORD;
          cls_kind  = KIND_ROUTER;
          cls_limit = IdxW'(1);
        end
      end
      8'd51: begin
        if (cls_len == 8'd4) begin
          cls_op    = OP_WORD;
          cls_kind  = KIND_LEASE;
          cls_limit = IdxW'(1);
        end
      end
      8'd12: begin
        if (cls_len >= 8'd1) begin
          cls_op    = OP_STR;
          cls_kind  = KIND_HOST_BYTE;
          cls_limit = (cls_len < 8'(MaxHostname)) ? cls_len[IdxW-1:0] : IdxW'(MaxHostname);
        end
      end
      default: begin
        if (code_q == auth_q) begin
          if (cls_len[1:0] == 2'b00) begin
            cls_op    = OP_HOST;
            cls_kind  = KIND_HOST_ADDR;
            cls_limit = (cls_len[7:2] < 6'(MaxHosts)) ? IdxW'(cls_len[7:2]) : IdxW'(MaxHosts);
          end
        end else if (code_q == comm_q) begin
          if (cls_len >= 8'd1) begin
            cls_op    = OP_STR;
            cls_kind  = KIND_COMM_BYTE;
            cls_limit = (cls_len < 8'(MaxCommunity)) ? cls_len[IdxW-1:0] :
                        IdxW'(MaxCommunity);
          end
        end
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    left_d  = left_q;
    taken_d = taken_q;
    push_o  = 1'b0;
    job_o   = '{op: OP_NONE, kind: KIND_DONE, limit: '0, done_en: 1'b0, done_val: DONE_END};
    wr_o    = '0;
    if (acc) begin
      case (phase_q)
        PH_CODE: begin
          if (fin) begin
            push_o         = 1'b1;
            job_o.done_en  = 1'b1;
            job_o.done_val = DONE_RAN_OUT;
          end else if (b == 8'd255) begin
            push_o         = 1'b1;
            job_o.done_en  = 1'b1;
            job_o.done_val = DONE_END;
            phase_d        = PH_DONE;
          end else if (b != 8'd0) begin
            code_d  = b;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          left_d  = b;
          taken_d = 8'd0;
          if (b == 8'd0) begin
            push_o         = (cls_op != OP_NONE) || fin;
            job_o.op       = cls_op;
            job_o.kind     = cls_kind;
            job_o.limit    = cls_limit;
            job_o.done_en  = fin;
            job_o.done_val = DONE_RAN_OUT;
            phase_d        = PH_CODE;
          end else if (fin) begin
            push_o         = 1'b1;
            job_o.done_en  = 1'b1;
            job_o.done_val = DONE_TRUNC;
            phase_d        = PH_CODE;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          wr_o.en   = taken_q < 8'(StoreDepth);
          wr_o.addr = taken_q;
          wr_o.data = b;
          taken_d   = taken_q + 8'd1;
          left_d    = left_q - 8'd1;
          if (left_q == 8'd1) begin
            push_o         = (cls_op != OP_NONE) || fin;
            job_o.op       = cls_op;
            job_o.kind     = cls_kind;
            job_o.limit    = cls_limit;
            job_o.done_en  = fin;
            job_o.done_val = DONE_RAN_OUT;
            phase_d        = PH_CODE;
          end else if (fin) begin
            push_o         = 1'b1;
            job_o.done_en  = 1'b1;
            job_o.done_val = DONE_TRUNC;
            phase_d        = PH_CODE;
          end
        end
        default: begin
          if (fin) begin
            phase_d = PH_CODE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      code_q  <= 8'd0;
      left_q  <= 8'd0;
      taken_q <= 8'd0;
      auth_q  <= AUTH_CODE_RESET;
      comm_q  <= COMM_CODE_RESET;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      left_q  <= left_d;
      taken_q <= taken_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_AUTH_CODE: auth_q <= cfg_data_i;
          REG_COMM_CODE: comm_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/dofe_queue.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor job queue
// Small first-in first-out buffer of jobs between front end and back end.
// ----------------------------------------------------------------------------
module dofe_queue
  import dofe_pkg::*;
#(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/dofe_back.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor back end
// Holds the value store and turns each job into its records, one store read
// at a time, through a registered output stage.
// ----------------------------------------------------------------------------
module dofe_back
  import dofe_pkg::*;
#(
  parameter int unsigned StoreDepth = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  store_wr_t wr_i,
  input  job_t      job_i,
  input  logic      q_empty_i,
  output logic      pop_o,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW = $clog2(StoreDepth);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_USE  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [7:0] mem [StoreDepth];
  logic [7:0] rd_data_q;

  logic [2:0]      state_q, state_d;
  job_t            job_q, job_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [1:0]      b_q, b_d;
  logic [23:0]     word_q, word_d;
  logic            out_valid_q;
  out_item_t       out_q;

  logic       rd_en;
  logic [7:0] rd_addr;
  logic       word_mode;
  logic       has_tail;
  logic       slot;
  logic       emit;
  out_item_t  rec;

  assign word_mode   = (job_q.op == OP_WORD) || (job_q.op == OP_HOST);
  assign has_tail    = (job_q.op == OP_STR) || (job_q.op == OP_HOST);
  assign slot        = !out_valid_q || !out_stall_i;
  assign busy_o      = state_q != S_IDLE;
  assign rd_addr     = word_mode ? {k_q, b_q} : {2'b00, k_q};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    k_d     = k_q;
    b_d     = b_q;
    word_d  = word_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    emit    = 1'b0;
    rec     = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          k_d     = '0;
          b_d     = 2'd0;
          word_d  = '0;
          state_d = (job_i.op == OP_NONE) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        if (k_q >= job_q.limit) begin
          state_d = has_tail ? S_TAIL : (job_q.done_en ? S_DONE : S_IDLE);
        end else begin
          rd_en   = 1'b1;
          state_d = S_USE;
        end
      end
      S_USE: begin
        if ((job_q.op == OP_STR) && (rd_data_q == 8'd0)) begin
          state_d = S_TAIL;
        end else if (word_mode && (b_q != 2'd3)) begin
          word_d  = {word_q[15:0], rd_data_q};
          b_d     = b_q + 2'd1;
          state_d = S_RD;
        end else if (slot) begin
          emit       = 1'b1;
          rec.kind   = job_q.kind;
          rec.value  = word_mode ? {word_q, rd_data_q} : {24'd0, rd_data_q};
          rec.index  = k_q;
          rec.last   = !has_tail && !job_q.done_en;
          k_d        = k_q + IdxW'(1);
          b_d        = 2'd0;
          state_d    = S_RD;
        end
      end
      S_TAIL: begin
        if (slot) begin
          emit      = 1'b1;
          rec.kind  = job_q.kind + 4'd1;
          rec.value = {{(32 - IdxW){1'b0}}, k_q};
          rec.index = '0;
          rec.last  = !job_q.done_en;
          state_d   = job_q.done_en ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (slot) begin
          emit      = 1'b1;
          rec.kind  = KIND_DONE;
          rec.value = {30'd0, job_q.done_val};
          rec.index = '0;
          rec.last  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    k_q    <= k_d;
    b_q    <= b_d;
    word_q <= word_d;
    if (emit) begin
      out_q <= rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/dhcp_option_field_extractor.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor
// Code and length bytes are taken unless the job queue is full; value bytes wait while
// the previous option's records drain, since the back end reads the same value store.
// Reset clears parser, queue and sequencer state; the value store is left unset.
// ----------------------------------------------------------------------------
`include "dhcp_option_field_extractor_macros.svh"

module dhcp_option_field_extractor
  import dofe_pkg::*;
#(
  parameter int unsigned MaxHostname  = DefMaxHostname,
  parameter int unsigned MaxCommunity = DefMaxCommunity,
  parameter int unsigned MaxHosts     = DefMaxHosts
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned StrCap     = (MaxHostname > MaxCommunity) ? MaxHostname : MaxCommunity;
  localparam int unsigned StoreDepth = (StrCap > 4 * MaxHosts) ? StrCap : 4 * MaxHosts;

  logic      push, pop, q_full, q_empty, back_busy;
  job_t      push_job, head_job;
  store_wr_t wr;

  dofe_front #(
    .MaxHostname (MaxHostname),
    .MaxCommunity(MaxCommunity),
    .MaxHosts    (MaxHosts),
    .StoreDepth  (StoreDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_empty_i  (q_empty),
    .back_busy_i(back_busy),
    .push_o     (push),
    .job_o      (push_job),
    .wr_o       (wr)
  );

  dofe_queue #(
    .Depth(DefQueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  dofe_back #(
    .StoreDepth(StoreDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .job_i      (head_job),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .busy_o     (back_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `DOFE_ASSERT_IMPLY(a_done_is_last, out_valid_o && (out_data_o.kind == KIND_DONE), out_data_o.last)
  `DOFE_ASSERT_IMPLY(a_store_quiet, wr.en, !back_busy && q_empty)
  `DOFE_ASSERT_IMPLY(a_no_push_full, push, !q_full)
  `DOFE_ASSERT_IMPLY(a_no_pop_empty, pop, !q_empty)

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// DHCP option field extractor testbench
// Sends option byte streams, from short directed packets to random packets
// with padding, truncation and end markers. A scoreboard works out the
// expected records of every accepted beat and compares them with the block's
// output under random sender gaps, receiver stalls and several register
// settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dofe_pkg::*;

  localparam int unsigned HostBytes  = DefMaxHosts * 4;
  localparam int unsigned StrCap     = (DefMaxHostname > DefMaxCommunity) ?
                                       DefMaxHostname : DefMaxCommunity;
  localparam int unsigned StoreDepth = (StrCap > HostBytes) ? StrCap : HostBytes;

  localparam int IdleLimit  = 5000;
  localparam int HoldCycles = 8;
  localparam int TailCycles = 20;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_SUBNET   = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_HOSTNAME = 8'd12;
  localparam logic [7:0] OPT_LEASE    = 8'd51;
  localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [3:0] KIND_NAME_LEN   = 4'd6;
  localparam logic [3:0] KIND_HOST_COUNT = 4'd8;
  localparam logic [3:0] KIND_COMM_LEN   = 4'd10;

  typedef enum logic [1:0] {
    ST_CODE,
    ST_LEN,
    ST_VALUE,
    ST_SKIP
  } parse_state_e;

  class dhcp_record_board;
    logic [7:0]   auth_code;
    logic [7:0]   comm_code;
    parse_state_e state;
    logic [7:0]   opt_code;
    int           left;
    int           taken;
    logic [7:0]   value_bytes [StoreDepth];
    out_item_t    pending_records [$];
    int           errors;

    function new();
      auth_code = AUTH_CODE_RESET;
      comm_code = COMM_CODE_RESET;
      state     = ST_CODE;
      opt_code  = '0;
      left      = 0;
      taken     = 0;
      errors    = 0;
      foreach (value_bytes[k]) value_bytes[k] = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      if (idx == REG_AUTH_CODE) auth_code = data;
      else if (idx == REG_COMM_CODE) comm_code = data;
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void add(logic [3:0] kind, logic [31:0] value, int idx);
      out_item_t r;
      r.kind  = kind;
      r.value = value;
      r.index = idx[IdxW-1:0];
      r.last  = 1'b0;
      pending_records.push_back(r);
    endfunction

    function logic [31:0] word_at(int pos);
      logic [31:0] w;
      w = '0;
      for (int k = 0; k < 4; k++) begin
        w = {w[23:0], (pos + k < StoreDepth) ? value_bytes[pos + k] : 8'h00};
      end
      return w;
    endfunction

    function void add_string(int cap, logic [3:0] byte_kind, logic [3:0] len_kind);
      int lim;
      int n;
      lim = (taken < cap) ? taken : cap;
      n = 0;
      while (n < lim && n < StoreDepth && value_bytes[n] != 8'h00) n++;
      for (int k = 0; k < n; k++) add(byte_kind, {24'h0, value_bytes[k]}, k);
      add(len_kind, n, 0);
    endfunction

    function void complete_option();
      int cnt;
      case (opt_code)
        OPT_MSGTYPE: if (taken >= 1) add(KIND_MSGTYPE, {24'h0, value_bytes[0]}, 0);
        OPT_SERVER:  if (taken == 4) add(KIND_SERVER, word_at(0), 0);
        OPT_SUBNET:  if (taken == 4) add(KIND_SUBNET, word_at(0), 0);
        OPT_ROUTER:  if (taken >= 4) add(KIND_ROUTER, word_at(0), 0);
        OPT_LEASE:   if (taken == 4) add(KIND_LEASE, word_at(0), 0);
        OPT_HOSTNAME: begin
          if (taken >= 1) add_string(DefMaxHostname, KIND_HOST_BYTE, KIND_NAME_LEN);
        end
        default: begin
          if (opt_code == auth_code) begin
            if ((taken % 4) == 0) begin
              cnt = taken / 4;
              if (cnt > DefMaxHosts) cnt = DefMaxHosts;
              for (int k = 0; k < cnt; k++) add(KIND_HOST_ADDR, word_at(k * 4), k);
              add(KIND_HOST_COUNT, cnt, 0);
            end
          end else if (opt_code == comm_code) begin
            if (taken >= 1) add_string(DefMaxCommunity, KIND_COMM_BYTE, KIND_COMM_LEN);
          end
        end
      endcase
    endfunction

    function void add_done(logic [1:0] why);
      add(KIND_DONE, {30'h0, why}, 0);
    endfunction

    function void parse_byte(in_item_t beat);
      int start;
      start = pending_records.size();
      case (state)
        ST_CODE: begin
          if (beat.last_byte) begin
            add_done(DONE_RAN_OUT);
          end else if (beat.stream_byte == OPT_END) begin
            add_done(DONE_END);
            state = ST_SKIP;
          end else if (beat.stream_byte != OPT_PAD) begin
            opt_code = beat.stream_byte;
            state = ST_LEN;
          end
        end
        ST_LEN: begin
          left  = beat.stream_byte;
          taken = 0;
          if (beat.stream_byte == 8'h00) begin
            complete_option();
            if (beat.last_byte) add_done(DONE_RAN_OUT);
            state = ST_CODE;
          end else if (beat.last_byte) begin
            add_done(DONE_TRUNC);
            state = ST_CODE;
          end else begin
            state = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (taken < StoreDepth) value_bytes[taken] = beat.stream_byte;
          taken++;
          left--;
          if (left == 0) begin
            complete_option();
            if (beat.last_byte) add_done(DONE_RAN_OUT);
            state = ST_CODE;
          end else if (beat.last_byte) begin
            add_done(DONE_TRUNC);
            state = ST_CODE;
          end
        end
        default: if (beat.last_byte) state = ST_CODE;
      endcase
      if (pending_records.size() > start) begin
        pending_records[pending_records.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_record(out_item_t got);
      out_item_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: expected no record, actual kind %0d value %h index %0d last %0b",
                 $time, got.kind, got.value, got.index, got.last);
        return;
      end
      want = pending_records.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      end
      if (got.value !== want.value) begin
        errors++;
        $display("%0t: value expected %h actual %h", $time, want.value, got.value);
      end
      if (got.index !== want.index) begin
        errors++;
        $display("%0t: index expected %0d actual %0d", $time, want.index, got.index);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  dhcp_record_board board;
  logic [7:0]       pkt [$];
  int               burst_left = 0;
  int               stall_mode = 0;
  int               stall_left = 0;
  int               idle_cycles = 0;

  dhcp_option_field_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Every accepted beat on the input, output or register channel restarts the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) board.parse_byte(in_data);
      if (out_valid_o && !out_stall) board.check_record(out_data_o);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles, %0d records outstanding",
                 $time, idle_cycles, board.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: b, last_byte: fin};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_pkt();
    foreach (pkt[k]) send_byte(pkt[k], k == pkt.size() - 1);
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    board.set_reg(idx, data);
  endtask

  function automatic int pick_len(int usual, int hi);
    return ($urandom_range(0, 3) != 0) ? usual : int'($urandom_range(0, hi));
  endfunction

  task automatic put_option(input logic [7:0] code, input int len, input int zero_in);
    pkt.push_back(code);
    pkt.push_back(8'(len));
    repeat (len) begin
      if (zero_in > 0 && $urandom_range(0, zero_in - 1) == 0) pkt.push_back(8'h00);
      else if (zero_in > 0) pkt.push_back(8'($urandom_range(1, 255)));
      else pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic int string_len();
    return ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 40))
                                       : int'($urandom_range(1, 10));
  endfunction

  task automatic add_option(input int sel);
    int r;
    case (sel)
      0: pkt.push_back(OPT_PAD);
      1: put_option(OPT_MSGTYPE, pick_len(1, 3), 0);
      2: put_option(OPT_SERVER, pick_len(4, 6), 0);
      3: put_option(OPT_SUBNET, pick_len(4, 6), 0);
      4: put_option(OPT_ROUTER, pick_len(4, 12), 0);
      5: put_option(OPT_LEASE, pick_len(4, 6), 0);
      6: put_option(OPT_HOSTNAME, string_len(), 10);
      7: begin
        r = $urandom_range(0, 7);
        if (r == 0) put_option(board.auth_code, 4 * $urandom_range(8, 10), 0);
        else if (r == 1) put_option(board.auth_code, $urandom_range(1, 11), 0);
        else put_option(board.auth_code, 4 * $urandom_range(0, 3), 0);
      end
      8: put_option(board.comm_code, string_len(), 10);
      default: begin
        put_option(8'($urandom_range(1, 254)),
                   ($urandom_range(0, 59) == 0) ? 255 : int'($urandom_range(0, 8)), 0);
      end
    endcase
  endtask

  task automatic build_packet();
    int style;
    int cut;
    pkt.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) add_option($urandom_range(0, 9));
      if (style <= 5) begin
        pkt.push_back(OPT_END);
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
      end else if (style >= 8) begin
        cut = $urandom_range(0, pkt.size() - 1);
        while (pkt.size() > cut + 1) void'(pkt.pop_back());
      end
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_packet();
      sent += pkt.size();
      send_pkt();
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pkt = {OPT_END};
    send_pkt();
    pkt = {OPT_PAD};
    send_pkt();
    pkt = {OPT_MSGTYPE, 8'd1, 8'd5, OPT_HOSTNAME, 8'd3, 8'h61, 8'h00, 8'h62,
           OPT_END, 8'hff, 8'h00};
    send_pkt();
    pkt = {OPT_SERVER, 8'd4, 8'hc0, 8'ha8, 8'h01, 8'hfe};
    send_pkt();
    pkt = {AUTH_CODE_RESET, 8'd0};
    send_pkt();
    pkt = {COMM_CODE_RESET, 8'd5, 8'h78};
    send_pkt();

    run_random(20);
    drain(HoldCycles);
    cfg_write(REG_AUTH_CODE, 8'd0);
    cfg_write(REG_COMM_CODE, 8'd255);
    run_random(15);
    drain(HoldCycles);
    cfg_write(REG_AUTH_CODE, 8'd255);
    cfg_write(REG_COMM_CODE, 8'd0);
    run_random(15);
    drain(HoldCycles);
    cfg_write(REG_AUTH_CODE, OPT_MSGTYPE);
    cfg_write(REG_COMM_CODE, OPT_HOSTNAME);
    run_random(15);
    drain(HoldCycles);
    cfg_write(REG_AUTH_CODE, 8'd200);
    cfg_write(REG_COMM_CODE, 8'd200);
    run_random(20);
    drain(HoldCycles);
    cfg_write(REG_AUTH_CODE, 8'($urandom_range(1, 254)));
    cfg_write(REG_COMM_CODE, 8'($urandom_range(1, 254)));
    run_random(20);
    drain(TailCycles);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
